>>> hdl/ihf_pkg.sv
package ihf_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [6:0] COUNT_MAX  = 7'd127;
	localparam logic [6:0] ETYPE_POS  = 7'd12;
	localparam logic [6:0] IP_BASE    = 7'd14;
	localparam logic [6:0] PROTO_POS  = 7'd23;
	localparam logic [6:0] SRC_IP_POS = 7'd26;
	localparam logic [6:0] DST_IP_POS = 7'd30;
	localparam logic [7:0] MIN_LEN    = 8'd34;
	localparam logic [7:0] PORT_END   = 8'd18;
	localparam logic [3:0] MIN_IHL    = 4'd5;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [2:0] REG_ETHERTYPE = 3'd0;
	localparam logic [2:0] REG_SRC_IP    = 3'd1;
	localparam logic [2:0] REG_DST_IP    = 3'd2;
	localparam logic [2:0] REG_SRC_PORT  = 3'd3;
	localparam logic [2:0] REG_DST_PORT  = 3'd4;
	localparam logic [2:0] REG_ENABLES   = 3'd5;

	typedef enum logic [3:0] {
		VERDICT_OK        = 4'd0,
		VERDICT_NOT_L4    = 4'd1,
		VERDICT_ETHERTYPE = 4'd2,
		VERDICT_SRC_IP    = 4'd3,
		VERDICT_DST_IP    = 4'd4,
		VERDICT_SRC_PORT  = 4'd5,
		VERDICT_DST_PORT  = 4'd6,
		VERDICT_TRUNCATED = 4'd7,
		VERDICT_BAD_IHL   = 4'd8
	} verdict_t;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [3:0]  ihl;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  len;
	} hdr_rec_t;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0]  enables;
	} cfg_t;

endpackage

>>> hdl/ihf_in_if.sv
interface ihf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

>>> hdl/ihf_out_if.sv
interface ihf_out_if;
	logic       valid;
	logic       ready;
	logic       accept;
	logic [3:0] verdict_code;

	modport source (output valid, output accept, output verdict_code, input ready);
	modport sink (input valid, input accept, input verdict_code, output ready);
endinterface

>>> hdl/ihf_front.sv
module ihf_front (
	input  logic              clk,
	input  logic              arst_n,
	ihf_in_if.sink            in_ch,
	output logic              push,
	output ihf_pkg::hdr_rec_t rec,
	input  logic              full
);
	import ihf_pkg::*;

	logic [6:0]  count_q;
	logic [15:0] ethertype_q;
	logic [3:0]  ihl_q;
	logic [7:0]  proto_q;
	logic [31:0] src_ip_q;
	logic [31:0] dst_ip_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;

	logic        take;
	logic [6:0]  pos;
	logic [6:0]  pbase;
	logic [7:0]  b;
	hdr_rec_t    nxt;

	assign in_ch.ready = !full;
	assign take        = in_ch.valid && !full;
	assign push        = take && in_ch.frame_last;
	assign rec         = nxt;
	assign pos         = count_q;
	assign b           = in_ch.frame_byte;
	assign pbase       = IP_BASE + {1'b0, ihl_q, 2'b00};

	always_comb begin
		nxt.ethertype = ethertype_q;
		nxt.ihl       = ihl_q;
		nxt.protocol  = proto_q;
		nxt.src_ip    = src_ip_q;
		nxt.dst_ip    = dst_ip_q;
		nxt.src_port  = src_port_q;
		nxt.dst_port  = dst_port_q;
		nxt.len       = {1'b0, count_q} + 8'd1;
		if (pos != COUNT_MAX) begin
			if (pos == ETYPE_POS || pos == ETYPE_POS + 7'd1)
				nxt.ethertype = {ethertype_q[7:0], b};
			if (pos == IP_BASE)
				nxt.ihl = b[3:0];
			if (pos == PROTO_POS)
				nxt.protocol = b;
			if (pos >= SRC_IP_POS && pos < SRC_IP_POS + 7'd4)
				nxt.src_ip = {src_ip_q[23:0], b};
			if (pos >= DST_IP_POS && pos < DST_IP_POS + 7'd4)
				nxt.dst_ip = {dst_ip_q[23:0], b};
			if (pos == pbase || pos == pbase + 7'd1)
				nxt.src_port = {src_port_q[7:0], b};
			if (pos == pbase + 7'd2 || pos == pbase + 7'd3)
				nxt.dst_port = {dst_port_q[7:0], b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ethertype_q <= '0;
			ihl_q       <= '0;
			proto_q     <= '0;
			src_ip_q    <= '0;
			dst_ip_q    <= '0;
			src_port_q  <= '0;
			dst_port_q  <= '0;
		end else if (take) begin
			if (in_ch.frame_last) begin
				count_q     <= '0;
				ethertype_q <= '0;
				ihl_q       <= '0;
				proto_q     <= '0;
				src_ip_q    <= '0;
				dst_ip_q    <= '0;
				src_port_q  <= '0;
				dst_port_q  <= '0;
			end else begin
				if (count_q != COUNT_MAX)
					count_q <= count_q + 7'd1;
				ethertype_q <= nxt.ethertype;
				ihl_q       <= nxt.ihl;
				proto_q     <= nxt.protocol;
				src_ip_q    <= nxt.src_ip;
				dst_ip_q    <= nxt.dst_ip;
				src_port_q  <= nxt.src_port;
				dst_port_q  <= nxt.dst_port;
			end
		end
	end

endmodule

>>> hdl/ihf_fifo.sv
module ihf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ihf_pkg::hdr_rec_t push_data,
	output logic              full,
	input  logic              pop,
	output ihf_pkg::hdr_rec_t head,
	output logic              empty
);
	import ihf_pkg::*;

	hdr_rec_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full  = count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
		end
	end

endmodule

>>> hdl/ihf_back.sv
module ihf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ihf_pkg::cfg_t     cfg,
	input  ihf_pkg::hdr_rec_t head,
	input  logic              empty,
	output logic              pop,
	ihf_out_if.source         out_ch
);
	import ihf_pkg::*;

	logic     valid_q;
	logic     accept_q;
	verdict_t code_q;
	verdict_t code;
	logic [7:0] port_end;

	assign port_end = PORT_END + {2'b00, head.ihl, 2'b00};
	assign pop      = !empty && (!valid_q || out_ch.ready);

	always_comb begin
		priority if (head.len < MIN_LEN)
			code = VERDICT_TRUNCATED;
		else if (head.ihl < MIN_IHL)
			code = VERDICT_BAD_IHL;
		else if (head.len < port_end)
			code = VERDICT_TRUNCATED;
		else if (head.protocol != PROTO_TCP && head.protocol != PROTO_UDP)
			code = VERDICT_NOT_L4;
		else if (head.ethertype != cfg.ethertype)
			code = VERDICT_ETHERTYPE;
		else if (cfg.enables[0] && head.src_ip != cfg.src_ip)
			code = VERDICT_SRC_IP;
		else if (cfg.enables[1] && head.dst_ip != cfg.dst_ip)
			code = VERDICT_DST_IP;
		else if (cfg.enables[2] && head.src_port != cfg.src_port)
			code = VERDICT_SRC_PORT;
		else if (cfg.enables[3] && head.dst_port != cfg.dst_port)
			code = VERDICT_DST_PORT;
		else
			code = VERDICT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ch.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			accept_q <= code == VERDICT_OK;
			code_q   <= code;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.accept       = accept_q;
	assign out_ch.verdict_code = code_q;

endmodule

>>> hdl/ipv4_tcp_udp_header_filter.sv
// IPv4 TCP/UDP header filter.
// in_ch carries an Ethernet frame one byte per transaction, frame_last set on
// the final byte. out_ch carries one verdict per frame: accept, and
// verdict_code naming the first failing check (0 when accepted).
// Throughput: one byte per cycle while in_ch.ready is high, with no gap needed between frames.
// The edge that takes the frame's last byte writes the header queue; the verdict
// register loads from the queue head once out_ch holds no verdict or is taking
// the held one, and presents the verdict on out_ch.
// A two-entry header queue sits between the byte parser and the verdict stage,
// so the parser keeps taking bytes while a verdict waits on a stalled out_ch;
// in_ch.ready drops only once both queue entries are held.
// Match registers sit on the APB port at byte addresses 0x00 to 0x14; writes
// land on the access phase, pready is tied high. Write them only when idle.
// Reset (arst_n low) clears the parser state and the queue, empties the
// output and restores the match registers to EtherType 0x0800, all address
// and port checks off.
module ipv4_tcp_udp_header_filter (
	input  logic        clk,
	input  logic        arst_n,
	ihf_in_if.sink      in_ch,
	ihf_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ihf_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       push;
	logic       full;
	logic       pop;
	logic       empty;
	hdr_rec_t   rec;
	hdr_rec_t   head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ethertype <= 16'h0800;
			cfg_q.src_ip    <= '0;
			cfg_q.dst_ip    <= '0;
			cfg_q.src_port  <= '0;
			cfg_q.dst_port  <= '0;
			cfg_q.enables   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ETHERTYPE: cfg_q.ethertype <= pwdata[15:0];
				REG_SRC_IP:    cfg_q.src_ip    <= pwdata;
				REG_DST_IP:    cfg_q.dst_ip    <= pwdata;
				REG_SRC_PORT:  cfg_q.src_port  <= pwdata[15:0];
				REG_DST_PORT:  cfg_q.dst_port  <= pwdata[15:0];
				REG_ENABLES:   cfg_q.enables   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ETHERTYPE: prdata = {16'h0, cfg_q.ethertype};
			REG_SRC_IP:    prdata = cfg_q.src_ip;
			REG_DST_IP:    prdata = cfg_q.dst_ip;
			REG_SRC_PORT:  prdata = {16'h0, cfg_q.src_port};
			REG_DST_PORT:  prdata = {16'h0, cfg_q.dst_port};
			REG_ENABLES:   prdata = {28'h0, cfg_q.enables};
			default:       prdata = '0;
		endcase
	end

	ihf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.push   (push),
		.rec    (rec),
		.full   (full)
	);

	ihf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (rec),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	ihf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

>>> verif/tb_ipv4_tcp_udp_header_filter.sv
module tb_ipv4_tcp_udp_header_filter;
	import ihf_pkg::*;

	localparam int ETH_TYPE_AT = 12;
	localparam int IPH_AT      = 14;
	localparam int PROTO_AT    = 23;
	localparam int SIP_AT      = 26;
	localparam int DIP_AT      = 30;
	localparam int HDR_END     = 34;
	localparam int POS_SAT     = 127;
	localparam int IHL_MIN     = 5;
	localparam logic [7:0] L4_TCP = 8'd6;
	localparam logic [7:0] L4_UDP = 8'd17;
	localparam int STALL_LIMIT = 2000;

	class filter_predictor;
		logic [15:0] want_etype;
		logic [31:0] want_sip;
		logic [31:0] want_dip;
		logic [15:0] want_sport;
		logic [15:0] want_dport;
		logic [3:0]  enables;
		logic [6:0]  pos;
		logic [15:0] got_etype;
		logic [3:0]  got_ihl;
		logic [7:0]  got_proto;
		logic [31:0] got_sip;
		logic [31:0] got_dip;
		logic [15:0] got_sport;
		logic [15:0] got_dport;
		verdict_t    pending_verdicts[$];
		int          errors;
		int          judged;
		int          per_code[9];

		function new();
			want_etype = 16'h0800;
			want_sip = '0;
			want_dip = '0;
			want_sport = '0;
			want_dport = '0;
			enables = '0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos = '0;
			got_etype = '0;
			got_ihl = '0;
			got_proto = '0;
			got_sip = '0;
			got_dip = '0;
			got_sport = '0;
			got_dport = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_ETHERTYPE: want_etype = v[15:0];
				REG_SRC_IP:    want_sip = v;
				REG_DST_IP:    want_dip = v;
				REG_SRC_PORT:  want_sport = v[15:0];
				REG_DST_PORT:  want_dport = v[15:0];
				REG_ENABLES:   enables = v[3:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_ETHERTYPE: return {16'h0, want_etype};
				REG_SRC_IP:    return want_sip;
				REG_DST_IP:    return want_dip;
				REG_SRC_PORT:  return {16'h0, want_sport};
				REG_DST_PORT:  return {16'h0, want_dport};
				REG_ENABLES:   return {28'h0, enables};
				default:       return '0;
			endcase
		endfunction

		function verdict_t judge(int len);
			if (len < HDR_END) return VERDICT_TRUNCATED;
			if (int'(got_ihl) < IHL_MIN) return VERDICT_BAD_IHL;
			if (len < IPH_AT + 4 * int'(got_ihl) + 4) return VERDICT_TRUNCATED;
			if (got_proto != L4_TCP && got_proto != L4_UDP) return VERDICT_NOT_L4;
			if (got_etype != want_etype) return VERDICT_ETHERTYPE;
			if (enables[0] && got_sip != want_sip) return VERDICT_SRC_IP;
			if (enables[1] && got_dip != want_dip) return VERDICT_DST_IP;
			if (enables[2] && got_sport != want_sport) return VERDICT_SRC_PORT;
			if (enables[3] && got_dport != want_dport) return VERDICT_DST_PORT;
			return VERDICT_OK;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			int p;
			int pb;
			p = int'(pos);
			// port offset follows the IHL held before this byte
			pb = IPH_AT + 4 * int'(got_ihl);
			if (p < POS_SAT) begin
				if (p == ETH_TYPE_AT || p == ETH_TYPE_AT + 1) got_etype = {got_etype[7:0], b};
				if (p == IPH_AT) got_ihl = b[3:0];
				if (p == PROTO_AT) got_proto = b;
				if (p >= SIP_AT && p < SIP_AT + 4) got_sip = {got_sip[23:0], b};
				if (p >= DIP_AT && p < DIP_AT + 4) got_dip = {got_dip[23:0], b};
				if (p == pb || p == pb + 1) got_sport = {got_sport[7:0], b};
				if (p == pb + 2 || p == pb + 3) got_dport = {got_dport[7:0], b};
			end
			if (!last) begin
				if (p < POS_SAT) pos = pos + 7'd1;
			end else begin
				pending_verdicts.push_back(judge(p + 1));
				clear_frame();
			end
		endfunction

		function void check_verdict(logic acc, logic [3:0] code);
			verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict accept=%0b code=%0d", $time, acc, code);
				errors++;
				return;
			end
			exp_v = pending_verdicts.pop_front();
			if (code !== 4'(exp_v)) begin
				$display("%0t: verdict_code expected %0d got %0d", $time, exp_v, code);
				errors++;
			end
			if (acc !== (exp_v == VERDICT_OK)) begin
				$display("%0t: accept expected %0b got %0b", $time, exp_v == VERDICT_OK, acc);
				errors++;
			end
			judged++;
			per_code[int'(exp_v)]++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ihf_in_if  in_ch();
	ihf_out_if out_ch();

	filter_predictor filt = new();
	bit calm;
	int sent_bytes;
	int idle_run;

	ipv4_tcp_udp_header_filter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [31:0] pick(input logic [31:0] want, input int w);
		logic [31:0] m;
		int r;
		m = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
		r = $urandom_range(0, 99);
		if (r < 75) return want;
		if (r < 88) return want ^ (32'd1 << $urandom_range(0, w - 1));
		return $urandom() & m;
	endfunction

	function automatic void place(ref logic [7:0] o[], input int at, input logic [31:0] v,
			input int n);
		for (int k = 0; k < n; k++) begin
			if (at + k < o.size()) o[at + k] = 8'(v >> (8 * (n - 1 - k)));
		end
	endfunction

	// transaction monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				filt.take_byte(in_ch.frame_byte, in_ch.frame_last);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				filt.check_verdict(out_ch.accept, out_ch.verdict_code);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int n;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = gap_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.frame_byte <= b;
		in_ch.frame_last <= l;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [15:0] et, input logic [7:0] vi, input logic [7:0] pr,
			input logic [31:0] si, input logic [31:0] di, input logic [15:0] sp,
			input logic [15:0] dp, input int len);
		logic [7:0] octets[];
		int pb;
		octets = new[len];
		foreach (octets[i]) octets[i] = 8'($urandom);
		pb = IPH_AT + 4 * int'(vi[3:0]);
		place(octets, ETH_TYPE_AT, et, 2);
		place(octets, IPH_AT, vi, 1);
		place(octets, PROTO_AT, pr, 1);
		place(octets, SIP_AT, si, 4);
		place(octets, DIP_AT, di, 4);
		if (int'(vi[3:0]) >= IHL_MIN) begin
			place(octets, pb, sp, 2);
			place(octets, pb + 2, dp, 2);
		end
		foreach (octets[i]) send_byte(octets[i], i == len - 1);
	endtask

	task automatic rand_frame();
		int kind;
		int ihl;
		int len;
		int r;
		logic [7:0] vi;
		logic [7:0] pr;
		kind = $urandom_range(0, 99);
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : IHL_MIN;
		r = $urandom_range(0, 19);
		pr = (r == 0) ? 8'($urandom) : ((r < 10) ? L4_TCP : L4_UDP);
		vi = ($urandom_range(0, 7) == 0) ? {4'($urandom), 4'(ihl)} : {4'h4, 4'(ihl)};
		if (kind < 65) begin
			len = IPH_AT + 4 * ihl + 4 +
				(($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8));
		end else if (kind < 77) begin
			len = $urandom_range(1, IPH_AT + 4 * ihl + 3);
		end else if (kind < 87) begin
			vi[3:0] = 4'($urandom_range(0, IHL_MIN - 1));
			len = $urandom_range(HDR_END, 60);
		end else if (kind < 95) begin
			send_frame(16'($urandom), 8'($urandom), 8'($urandom), $urandom(), $urandom(),
				16'($urandom), 16'($urandom), $urandom_range(1, 70));
			return;
		end else begin
			len = $urandom_range(120, 170);
		end
		send_frame(16'(pick(filt.want_etype, 16)), vi, pr, pick(filt.want_sip, 32),
			pick(filt.want_dip, 32), 16'(pick(filt.want_sport, 16)),
			16'(pick(filt.want_dport, 16)), len);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (filt.pending_verdicts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input logic [2:0] idx, input logic [31:0] v);
		logic [31:0] m;
		case (idx)
			REG_SRC_IP, REG_DST_IP: m = 32'hFFFF_FFFF;
			REG_ENABLES:            m = 32'h0000_000F;
			default:                m = 32'h0000_FFFF;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		filt.set_reg(idx, v);
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & m) !== filt.reg_value(idx)) begin
			$display("%0t: register %0d readback expected %h got %h", $time, idx,
				filt.reg_value(idx), prdata & m);
			filt.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_filter(input logic [31:0] et, input logic [31:0] si, input logic [31:0] di,
			input logic [31:0] sp, input logic [31:0] dp, input logic [31:0] en);
		program_reg(REG_ETHERTYPE, et);
		program_reg(REG_SRC_IP, si);
		program_reg(REG_DST_IP, di);
		program_reg(REG_SRC_PORT, sp);
		program_reg(REG_DST_PORT, dp);
		program_reg(REG_ENABLES, en);
	endtask

	initial begin
		int frames;
		string mix;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.frame_byte <= '0;
		in_ch.frame_last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset match settings: EtherType 0x0800, all wildcards
		send_frame(16'h0800, 8'h45, L4_TCP, '0, '0, '0, '0, 1);
		send_frame(16'h0800, 8'h45, L4_TCP, 32'h0A000001, 32'h0A000002, 16'h0000, 16'h0000, 38);
		send_frame(16'h0800, 8'h45, L4_UDP, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 38);
		send_frame(16'h0800, 8'h45, L4_TCP, '0, '0, '0, '0, 37);
		send_frame(16'h0800, 8'h45, L4_TCP, '0, '0, '0, '0, 33);
		send_frame(16'h0800, 8'h45, L4_TCP, '0, '0, '0, '0, 34);
		send_frame(16'h0800, 8'h45, 8'd1, '0, '0, '0, '0, 38);
		send_frame(16'h86DD, 8'h45, L4_UDP, '0, '0, '0, '0, 38);
		send_frame(16'h0800, 8'h44, L4_TCP, '0, '0, '0, '0, 38);
		send_frame(16'h0800, 8'hF0, L4_TCP, '0, '0, '0, '0, 38);
		send_frame(16'h0800, 8'h4F, L4_UDP, '0, '0, '0, '0, 78);
		send_frame(16'h0800, 8'h4F, L4_UDP, '0, '0, '0, '0, 77);
		send_frame(16'h0800, 8'h45, L4_TCP, '0, '0, '0, '0, 130);
		drain();

		set_filter(32'h0800, 32'hC0A80001, 32'h0A000002, 32'h1234, 32'h0050, 32'hF);
		send_frame(16'h0800, 8'h45, L4_TCP, 32'hC0A80001, 32'h0A000002, 16'h1234, 16'h0050, 40);
		send_frame(16'h0800, 8'h45, L4_TCP, 32'hC0A80003, 32'h0A000002, 16'h1234, 16'h0050, 40);
		send_frame(16'h0800, 8'h45, L4_UDP, 32'hC0A80001, 32'h0A000000, 16'h1234, 16'h0050, 40);
		send_frame(16'h0800, 8'h46, L4_UDP, 32'hC0A80001, 32'h0A000002, 16'h1235, 16'h0050, 42);
		send_frame(16'h0800, 8'h45, L4_TCP, 32'hC0A80001, 32'h0A000002, 16'h1234, 16'h8050, 40);
		send_frame(16'h0801, 8'h45, 8'd17 ^ 8'h80, 32'h0, 32'h0, 16'h0, 16'h0, 40);
		send_frame(16'h0801, 8'h45, L4_TCP, 32'h0, 32'h0, 16'h0, 16'h0, 40);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_filter(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hF);
				1: set_filter(32'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF, 32'hF);
				2: set_filter(32'h0800, $urandom(), $urandom(), $urandom(), $urandom(), 32'h0);
				3: set_filter(32'h86DD, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom_range(0, 15));
				4: set_filter(32'h0800, $urandom(), $urandom(), $urandom(), $urandom(), 32'h5);
				default: set_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
			endcase
			calm = (ph == 4);
			frames = 0;
			while (frames < 1 || (ph == 5 && sent_bytes < 1000)) begin
				rand_frame();
				frames++;
			end
			drain();
		end
		calm = 1'b0;
		repeat (8) @(posedge clk);

		mix = "";
		foreach (filt.per_code[i]) mix = {mix, $sformatf(" %0d:%0d", i, filt.per_code[i])};
		$display("%0d frames judged from %0d bytes over eight match settings and extremes",
			filt.judged, sent_bytes);
		$display("verdicts by code:%s", mix);
		if (filt.errors == 0 && filt.pending_verdicts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
